// ===== rtl/core/zab_pkg.sv =====
// Shared types, geometry constants and codes for the zoned adaptive binarizer.
`default_nettype none

package zab_pkg;

  // Frame and zone grid geometry.
  localparam int FRAME_WIDTH  = 1280;
  localparam int FRAME_HEIGHT = 480;
  localparam int ZONES_ACROSS = 12;
  localparam int ZONES_DOWN   = 2;

  localparam int ZONE_COUNT = ZONES_ACROSS * ZONES_DOWN;
  localparam int ZONE_W     = FRAME_WIDTH / ZONES_ACROSS;
  localparam int ZONE_H     = (FRAME_HEIGHT / ZONES_DOWN) > 0 ? (FRAME_HEIGHT / ZONES_DOWN) : 1;

  // Index widths for the zone grid.
  localparam int ZONE_IDX_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int COL_W      = (ZONES_ACROSS > 1) ? $clog2(ZONES_ACROSS) : 1;
  localparam int ROW_W      = (ZONES_DOWN > 1) ? $clog2(ZONES_DOWN) : 1;

  // Width of the signed coordinate arithmetic used for tag overlap tests.
  localparam int COORD_W = 16;

  // Number of zones that have a bit in the marks word.
  localparam int MARKS_W = 24;

  // Threshold ramp loaded at reset.
  localparam int RAMP_BASE = 10;
  localparam int RAMP_SPAN = 230;

  // Operation codes.
  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_MARK  = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_WRITE = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CYCLING_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_INVERT_ENABLE     = 3'd1;
  localparam logic [2:0] CFG_MIRROR_HORIZONTAL = 3'd2;
  localparam logic [2:0] CFG_MIRROR_VERTICAL   = 3'd3;
  localparam logic [2:0] CFG_ZONE_PADDING      = 3'd4;
  localparam logic [2:0] CFG_CYCLE_MINIMUM     = 3'd5;
  localparam logic [2:0] CFG_CYCLE_MAXIMUM     = 3'd6;
  localparam logic [2:0] CFG_CYCLE_SPEED       = 3'd7;

  // One input item.
  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] pixel_x;
    logic [8:0]  pixel_y;
    logic [7:0]  live_value;
    logic [7:0]  background_value;
    logic [10:0] tag_x;
    logic [8:0]  tag_y;
    logic [4:0]  zone_index;
    logic [7:0]  write_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  binary_pixel;
    logic [7:0]  difference;
    logic [7:0]  threshold_value;
    logic [23:0] zone_marks;
  } out_item_t;

  // Reset value of the threshold of zone i.
  function automatic logic [7:0] ramp_value(input int i);
    return 8'(RAMP_BASE + (i * RAMP_SPAN) / ZONE_COUNT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zoned_adaptive_binarizer.sv =====
// Top level of the zoned adaptive binarizer: zone thresholds, marks and result register.
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data  (zab_pkg::in_item_t)
// out      output     out_valid / out_ready  out_data (zab_pkg::out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (8 bits)
//
// Every item is worked out from the input ports and the zone state and lands in
// the result register at the edge that accepts it.
// One item per cycle is sustained while the output is not stalled; the result register is the only stage.
// A stalled output holds the result; a new item is taken in the same cycle the
// waiting result leaves. Reset loads the threshold ramp and clears all marks.
// Configuration writes are always taken.

module zoned_adaptive_binarizer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire zab_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output zab_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import zab_pkg::*;

  // Configuration registers.
  logic       cycling_en_r;
  logic       invert_en_r;
  logic       mirror_h_r;
  logic       mirror_v_r;
  logic [7:0] pad_r;
  logic [7:0] cyc_min_r;
  logic [7:0] cyc_max_r;
  logic [7:0] cyc_speed_r;

  // Zone state.
  logic [7:0]            thr_r   [ZONE_COUNT];
  logic [7:0]            thr_nxt [ZONE_COUNT];
  logic [ZONE_COUNT-1:0] occ_r;
  logic [ZONE_COUNT-1:0] occ_nxt;

  // Result register.
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  logic in_fire;

  // Pixel path signals.
  logic [COL_W:0]          col_cnt;
  logic [ROW_W:0]          row_cnt;
  logic [ZONE_IDX_W-1:0]   pix_zone;
  logic [ZONE_IDX_W-1:0]   rd_idx;
  logic [7:0]              rd_thr;
  logic [7:0]              abs_diff;
  logic [7:0]              pix_diff;

  // Tag overlap signals.
  logic signed [COORD_W-1:0] tag_sx;
  logic signed [COORD_W-1:0] tag_sy;
  logic signed [COORD_W-1:0] pad_s;
  logic [ZONES_ACROSS-1:0]   col_hit;
  logic [ZONES_DOWN-1:0]     row_hit;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycling_en_r <= 1'b0;
      invert_en_r  <= 1'b0;
      mirror_h_r   <= 1'b1;
      mirror_v_r   <= 1'b0;
      pad_r        <= 8'd0;
      cyc_min_r    <= 8'd0;
      cyc_max_r    <= 8'd255;
      cyc_speed_r  <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CYCLING_ENABLE:    cycling_en_r <= cfg_data[0];
        CFG_INVERT_ENABLE:     invert_en_r  <= cfg_data[0];
        CFG_MIRROR_HORIZONTAL: mirror_h_r   <= cfg_data[0];
        CFG_MIRROR_VERTICAL:   mirror_v_r   <= cfg_data[0];
        CFG_ZONE_PADDING:      pad_r        <= cfg_data;
        CFG_CYCLE_MINIMUM:     cyc_min_r    <= cfg_data;
        CFG_CYCLE_MAXIMUM:     cyc_max_r    <= cfg_data;
        CFG_CYCLE_SPEED:       cyc_speed_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pixel zone: count the zone boundaries at or left of / above the pixel.
  // The count stops at the last column and row, which clamps pixels past the grid.
  always_comb begin
    col_cnt = '0;
    for (int k = 1; k < ZONES_ACROSS; k++) begin
      if (COORD_W'(in_data.pixel_x) >= COORD_W'(k * ZONE_W)) begin
        col_cnt = col_cnt + 1'b1;
      end
    end
    row_cnt = '0;
    for (int k = 1; k < ZONES_DOWN; k++) begin
      if (COORD_W'(in_data.pixel_y) >= COORD_W'(k * ZONE_H)) begin
        row_cnt = row_cnt + 1'b1;
      end
    end
  end

  assign pix_zone = ZONE_IDX_W'(col_cnt) + ZONE_IDX_W'(row_cnt * ZONES_ACROSS);

  // Single threshold read port shared by the pixel and read operations.
  assign rd_idx = (in_data.op == OP_READ) ? ZONE_IDX_W'(in_data.zone_index) : pix_zone;
  assign rd_thr = (32'(rd_idx) < ZONE_COUNT) ? thr_r[rd_idx] : 8'd0;

  // Background difference with optional inversion.
  assign abs_diff = (in_data.live_value >= in_data.background_value) ?
                    (in_data.live_value - in_data.background_value) :
                    (in_data.background_value - in_data.live_value);
  assign pix_diff = invert_en_r ? (8'd255 - abs_diff) : abs_diff;

  // Tag position after optional mirroring, and the padded overlap per column and row.
  assign pad_s  = $signed(COORD_W'(pad_r));
  assign tag_sx = mirror_h_r ?
                  ($signed(COORD_W'(FRAME_WIDTH)) - $signed(COORD_W'(in_data.tag_x))) :
                  $signed(COORD_W'(in_data.tag_x));
  assign tag_sy = mirror_v_r ?
                  ($signed(COORD_W'(FRAME_HEIGHT)) - $signed(COORD_W'(in_data.tag_y))) :
                  $signed(COORD_W'(in_data.tag_y));

  always_comb begin
    for (int c = 0; c < ZONES_ACROSS; c++) begin
      col_hit[c] = (tag_sx + pad_s > $signed(COORD_W'(c * ZONE_W))) &&
                   (tag_sx - pad_s < $signed(COORD_W'((c + 1) * ZONE_W)));
    end
    for (int r = 0; r < ZONES_DOWN; r++) begin
      row_hit[r] = (tag_sy + pad_s > $signed(COORD_W'(r * ZONE_H))) &&
                   (tag_sy - pad_s < $signed(COORD_W'((r + 1) * ZONE_H)));
    end
  end

  // Next zone state for the accepted item.
  always_comb begin
    logic [8:0] sum;
    sum     = '0;
    thr_nxt = thr_r;
    occ_nxt = occ_r;
    if (in_fire) begin
      unique case (in_data.op)
        OP_MARK: begin
          if (cycling_en_r) begin
            for (int i = 0; i < ZONE_COUNT; i++) begin
              if (col_hit[i % ZONES_ACROSS] && row_hit[i / ZONES_ACROSS]) begin
                occ_nxt[i] = 1'b1;
              end
            end
          end
        end
        OP_CLEAR: begin
          if (cycling_en_r) begin
            occ_nxt = '0;
          end
        end
        OP_TICK: begin
          if (cycling_en_r) begin
            for (int i = 0; i < ZONE_COUNT; i++) begin
              sum = {1'b0, thr_r[i]} + {1'b0, cyc_speed_r};
              if (!occ_r[i]) begin
                thr_nxt[i] = (sum >= {1'b0, cyc_max_r}) ? cyc_min_r : sum[7:0];
              end
            end
          end
        end
        OP_WRITE: begin
          for (int i = 0; i < ZONE_COUNT; i++) begin
            if (32'(in_data.zone_index) == i) begin
              thr_nxt[i] = in_data.write_value;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result item for the accepted item.
  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < MARKS_W; i++) begin
      if (i < ZONE_COUNT) begin
        out_data_nxt.zone_marks[i] = occ_nxt[i];
      end
    end
    if (in_data.op == OP_PIXEL) begin
      out_data_nxt.difference      = pix_diff;
      out_data_nxt.threshold_value = rd_thr;
      out_data_nxt.binary_pixel    = (pix_diff <= rd_thr) ? 8'd0 : 8'd255;
    end else if (in_data.op == OP_READ) begin
      out_data_nxt.threshold_value = rd_thr;
    end
  end

  // Zone state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        thr_r[i] <= ramp_value(i);
      end
      occ_r <= '0;
    end else begin
      thr_r <= thr_nxt;
      occ_r <= occ_nxt;
    end
  end

  // Result register: loads on accept, empties when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A binarized pixel is 0 or 255 and agrees with its difference and threshold.
  a_binary_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.binary_pixel == 8'd0) ==
                     (out_data_r.difference <= out_data_r.threshold_value)) &&
                    (out_data_r.binary_pixel == 8'd0 || out_data_r.binary_pixel == 8'd255))
    else $error("binary pixel disagrees with difference and threshold");

  // Only pixel items carry a difference.
  a_diff_pixel_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op != OP_PIXEL) |=> (out_data_r.difference == 8'd0))
    else $error("difference set for a non-pixel item");

  // A cycle tick never changes the zone marks.
  a_tick_keeps_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_TICK) |=> (occ_r == $past(occ_r)))
    else $error("cycle tick changed zone marks");

  // Clearing with cycling enabled empties the marks.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_CLEAR && cycling_en_r) |=> (occ_r == '0))
    else $error("clear left zone marks set");

  // Marks only grow on a mark item.
  a_marks_grow_on_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op != OP_MARK) |=> ((occ_r & ~$past(occ_r)) == '0))
    else $error("zone mark set outside a mark item");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the zoned adaptive binarizer, with its own model of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zab_pkg::*;

  // Op codes that the block leaves without effect.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Items waiting to be offered and results predicted for accepted items.
  in_item_t  queued_ops[$];
  out_item_t predicted_outs[$];
  out_item_t want;

  int ops_taken = 0;
  int queued_total = 0;
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic rx_hold = 1'b0;

  // Model state: zone thresholds, zone marks and register copies.
  logic [7:0] model_thr[ZONE_COUNT];
  logic       model_marked[ZONE_COUNT];
  logic       cyc_en, inv_en, mir_h, mir_v;
  logic [7:0] pad_px, thr_min, thr_max, thr_speed;

  zoned_adaptive_binarizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bring the model to its reset state: threshold ramp, no marks, default registers.
  task automatic model_reset();
    for (int i = 0; i < ZONE_COUNT; i++) begin
      model_thr[i] = 8'(10 + (i * 230) / ZONE_COUNT);
      model_marked[i] = 1'b0;
    end
    cyc_en = 1'b0;
    inv_en = 1'b0;
    mir_h = 1'b1;
    mir_v = 1'b0;
    pad_px = 8'd0;
    thr_min = 8'd0;
    thr_max = 8'd255;
    thr_speed = 8'd1;
  endtask

  // Update the register copy after a write has been taken.
  task automatic apply_reg(input logic [2:0] idx, input logic [7:0] val);
    case (idx)
      CFG_CYCLING_ENABLE:    cyc_en = val[0];
      CFG_INVERT_ENABLE:     inv_en = val[0];
      CFG_MIRROR_HORIZONTAL: mir_h = val[0];
      CFG_MIRROR_VERTICAL:   mir_v = val[0];
      CFG_ZONE_PADDING:      pad_px = val;
      CFG_CYCLE_MINIMUM:     thr_min = val;
      CFG_CYCLE_MAXIMUM:     thr_max = val;
      CFG_CYCLE_SPEED:       thr_speed = val;
      default: ;
    endcase
  endtask

  // Work out the result of one item and advance the zone state.
  function automatic out_item_t binarize_step(input in_item_t it);
    out_item_t r;
    int col, row, tx, ty, zx, zy, pad;
    logic [7:0] d;
    logic [8:0] s;
    r = '0;
    case (it.op)
      OP_PIXEL: begin
        col = int'(it.pixel_x) / ZONE_W;
        row = int'(it.pixel_y) / ZONE_H;
        if (col > ZONES_ACROSS - 1) col = ZONES_ACROSS - 1;
        if (row > ZONES_DOWN - 1) row = ZONES_DOWN - 1;
        d = (it.live_value >= it.background_value) ? it.live_value - it.background_value
                                                   : it.background_value - it.live_value;
        if (inv_en) d = 8'd255 - d;
        r.difference = d;
        r.threshold_value = model_thr[col + row * ZONES_ACROSS];
        r.binary_pixel = (d <= r.threshold_value) ? 8'd0 : 8'd255;
      end
      OP_MARK: begin
        if (cyc_en) begin
          pad = int'(pad_px);
          tx = int'(it.tag_x);
          ty = int'(it.tag_y);
          if (mir_h) tx = FRAME_WIDTH - tx;
          if (mir_v) ty = FRAME_HEIGHT - ty;
          for (int i = 0; i < ZONE_COUNT; i++) begin
            zx = (i % ZONES_ACROSS) * ZONE_W;
            zy = (i / ZONES_ACROSS) * ZONE_H;
            if (tx + pad > zx && tx - pad < zx + ZONE_W &&
                ty + pad > zy && ty - pad < zy + ZONE_H)
              model_marked[i] = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        if (cyc_en)
          for (int i = 0; i < ZONE_COUNT; i++) model_marked[i] = 1'b0;
      end
      OP_TICK: begin
        // The 9-bit sum is compared, so a carry out always wraps.
        if (cyc_en)
          for (int i = 0; i < ZONE_COUNT; i++)
            if (!model_marked[i]) begin
              s = {1'b0, model_thr[i]} + {1'b0, thr_speed};
              if (s >= {1'b0, thr_max}) s = {1'b0, thr_min};
              model_thr[i] = s[7:0];
            end
      end
      OP_WRITE: begin
        if (int'(it.zone_index) < ZONE_COUNT) model_thr[it.zone_index] = it.write_value;
      end
      OP_READ: begin
        if (int'(it.zone_index) < ZONE_COUNT) r.threshold_value = model_thr[it.zone_index];
      end
      default: ;
    endcase
    for (int i = 0; i < ZONE_COUNT && i < MARKS_W; i++) r.zone_marks[i] = model_marked[i];
    return r;
  endfunction

  // Input driver: offers queued items, predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_outs = {predicted_outs, binarize_step(in_data)};
        ops_taken++;
      end
      if (!in_valid || in_ready) begin
        if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= queued_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares every taken result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_outs.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: bin=%0d diff=%0d thr=%0d marks=%06h",
                     out_data.binary_pixel, out_data.difference,
                     out_data.threshold_value, out_data.zone_marks);
        end else begin
          want = predicted_outs.pop_front();
          if (out_data.binary_pixel !== want.binary_pixel ||
              out_data.difference !== want.difference ||
              out_data.threshold_value !== want.threshold_value ||
              out_data.zone_marks !== want.zone_marks) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch: exp %0d/%0d/%0d/%06h got %0d/%0d/%0d/%06h",
                       want.binary_pixel, want.difference, want.threshold_value,
                       want.zone_marks, out_data.binary_pixel, out_data.difference,
                       out_data.threshold_value, out_data.zone_marks);
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall once traffic is flowing, so the block backs up its input.
  initial begin
    wait (ops_taken >= 60);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // Write one register; called at a clock edge, leaves cfg_valid high.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // Write all eight registers back to back.
  task automatic program_regs(input logic cyc, input logic inv, input logic mh,
                              input logic mv, input logic [7:0] pad, input logic [7:0] mn,
                              input logic [7:0] mx, input logic [7:0] sp);
    write_reg(CFG_CYCLING_ENABLE, {7'd0, cyc});
    write_reg(CFG_INVERT_ENABLE, {7'd0, inv});
    write_reg(CFG_MIRROR_HORIZONTAL, {7'd0, mh});
    write_reg(CFG_MIRROR_VERTICAL, {7'd0, mv});
    write_reg(CFG_ZONE_PADDING, pad);
    write_reg(CFG_CYCLE_MINIMUM, mn);
    write_reg(CFG_CYCLE_MAXIMUM, mx);
    write_reg(CFG_CYCLE_SPEED, sp);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued item has been taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_ops.size() != 0 || in_valid || predicted_outs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_op(input in_item_t it);
    queued_ops = {queued_ops, it};
    queued_total++;
  endtask

  function automatic in_item_t make_item(input logic [2:0] op, input int px, input int py,
                                         input int lv, input int bg, input int tx,
                                         input int ty, input int zi, input int wv);
    in_item_t it;
    it.op = op;
    it.pixel_x = 11'(px);
    it.pixel_y = 9'(py);
    it.live_value = 8'(lv);
    it.background_value = 8'(bg);
    it.tag_x = 11'(tx);
    it.tag_y = 9'(ty);
    it.zone_index = 5'(zi);
    it.write_value = 8'(wv);
    return it;
  endfunction

  // Random content for every field; coordinates mostly inside the frame.
  function automatic in_item_t noise_item(input logic [2:0] op);
    in_item_t it;
    it.op = op;
    it.pixel_x = ($urandom_range(99) < 85) ? 11'($urandom_range(1279)) : 11'($urandom);
    it.pixel_y = ($urandom_range(99) < 85) ? 9'($urandom_range(479)) : 9'($urandom);
    it.live_value = 8'($urandom);
    it.background_value = ($urandom_range(9) == 0) ? it.live_value : 8'($urandom);
    it.tag_x = ($urandom_range(99) < 80) ? 11'($urandom_range(1279)) : 11'($urandom);
    it.tag_y = ($urandom_range(99) < 80) ? 9'($urandom_range(479)) : 9'($urandom);
    it.zone_index = ($urandom_range(99) < 80) ? 5'($urandom_range(ZONE_COUNT - 1))
                                             : 5'($urandom);
    it.write_value = 8'($urandom);
    return it;
  endfunction

  // Mostly frame-like sequences (clear, marks, ticks, pixels, a threshold access),
  // the rest single items with any op code.
  task automatic fill_random(input int n_items);
    int stop_at, n;
    stop_at = queued_total + n_items;
    while (queued_total < stop_at) begin
      if ($urandom_range(99) < 75) begin
        push_op(noise_item(OP_CLEAR));
        n = $urandom_range(1, 3);
        repeat (n) push_op(noise_item(OP_MARK));
        n = $urandom_range(1, 2);
        repeat (n) push_op(noise_item(OP_TICK));
        n = $urandom_range(4, 12);
        repeat (n) push_op(noise_item(OP_PIXEL));
        push_op(noise_item($urandom_range(1) ? OP_WRITE : OP_READ));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) push_op(noise_item(3'($urandom)));
      end
    end
  endtask

  // Random register setting, cycling mostly on and speeds mostly small.
  task automatic random_regs();
    program_regs($urandom_range(3) != 0, 1'($urandom), 1'($urandom), 1'($urandom),
                 ($urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom)),
                 8'($urandom_range(120)), 8'($urandom_range(100, 255)),
                 ($urandom_range(3) != 0 ? 8'($urandom_range(1, 20)) : 8'($urandom)));
  endtask

  // Main sequence: reset, directed items, then random phases under several settings.
  initial begin
    model_reset();
    rst_n = 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 66;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: ramp reads, range ends, clamping, equal-threshold pixel,
    // cycling ops that must do nothing, spare op codes, out-of-range zones.
    push_op(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 23, 0));
    push_op(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 31, 0));
    push_op(make_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 24, 255));
    push_op(make_item(OP_PIXEL, 0, 0, 255, 0, 0, 0, 0, 0));
    push_op(make_item(OP_PIXEL, 2047, 511, 0, 255, 0, 0, 0, 0));
    push_op(make_item(OP_PIXEL, 1279, 479, 100, 100, 0, 0, 0, 0));
    push_op(make_item(OP_PIXEL, 105, 239, 20, 10, 0, 0, 0, 0));
    push_op(make_item(OP_MARK, 0, 0, 0, 0, 640, 240, 0, 0));
    push_op(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_SPARE6, 2047, 511, 255, 255, 2047, 511, 31, 255));
    push_op(make_item(OP_SPARE7, 2047, 511, 255, 255, 2047, 511, 31, 255));
    wait_idle();

    // Cycling on, no mirroring: corner and boundary tags, wrapping tick, inverted pixel.
    program_regs(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 8'd5, 8'd200, 8'd255);
    push_op(make_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 5, 250));
    push_op(make_item(OP_MARK, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_MARK, 0, 0, 0, 0, 1279, 479, 0, 0));
    push_op(make_item(OP_MARK, 0, 0, 0, 0, 107, 241, 0, 0));
    push_op(make_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 5, 0));
    push_op(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 23, 0));
    push_op(make_item(OP_PIXEL, 1279, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    push_op(make_item(OP_WRITE, 0, 0, 0, 0, 0, 0, 31, 0));
    wait_idle();

    for (int ph = 1; ph <= 6; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 66;
        recv_idle_pct = 30;
      end else if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        1: program_regs(1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd0, 8'd255);
        2: program_regs(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
        default: random_regs();
      endcase
      fill_random(105);
      wait_idle();
    end

    if (err_count == 0 && predicted_outs.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== zoned_adaptive_binarizer.f =====
rtl/core/zab_pkg.sv
rtl/core/zoned_adaptive_binarizer.sv
tb/sv/tb.sv
